// File: hw/rtl/bscp_pkg.sv
package bscp_pkg;

  localparam int CoordW  = 24;
  localparam int CoefW   = 30;
  localparam int QuotBits = 30;

  localparam logic [1:0] StatOk    = 2'd0;
  localparam logic [1:0] StatFew   = 2'd1;
  localparam logic [1:0] StatTrunc = 2'd2;

  // ceil(2^28 / 3): exact floor division by three for operands below 2^27.
  localparam logic [CoefW-1:0] Recip3 = 30'd89478486;

  typedef struct packed {
    logic signed [CoordW-1:0] anchor_x;
    logic signed [CoordW-1:0] anchor_y;
    logic                     last_anchor;
  } anchor_t;

  typedef struct packed {
    logic signed [CoordW-1:0] handle_out_x;
    logic signed [CoordW-1:0] handle_out_y;
    logic signed [CoordW-1:0] handle_in_x;
    logic signed [CoordW-1:0] handle_in_y;
    logic [5:0]               segment_number;
    logic [1:0]               status;
    logic                     last_segment;
  } handles_t;

  typedef struct packed {
    logic             start;
    logic [CoefW-1:0] prev;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [CoefW-1:0] quot;
  } div_rsp_t;

endpackage

// File: hw/rtl/bscp_coef_div.sv
module bscp_coef_div import bscp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic             busy_q;
  logic             done_q;
  logic [4:0]       bit_q;
  logic [32:0]      id_q;
  logic [29:0]      ix_q;
  logic [32:0]      rem_q;
  logic [CoefW-1:0] quot_q;

  logic [32:0] id_new;
  logic [33:0] rem_sh;
  logic [33:0] rem_diff;
  logic        ge;

  // Coefficient is round(2^60 / id) with id = 4.0 - previous coefficient in Q2.30.
  assign id_new   = 33'h1_0000_0000 - {3'b000, req_i.prev};
  assign rem_sh   = {rem_q, ix_q[bit_q]};
  assign ge       = rem_sh >= {1'b0, id_q};
  assign rem_diff = rem_sh - {1'b0, id_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      bit_q <= 5'(QuotBits - 1);
      id_q  <= id_new;
      ix_q  <= id_new[30:1];
      rem_q <= 33'h0_4000_0000 + {31'b0, id_new[32:31]};
    end else if (busy_q) begin
      rem_q  <= ge ? rem_diff[32:0] : rem_sh[32:0];
      quot_q <= {quot_q[CoefW-2:0], ge};
      bit_q  <= bit_q - 5'd1;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

// File: hw/rtl/bezier_spline_control_points_top.sv
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_stall_o   anchor_t (one anchor per transfer)
// out       output     out_valid_o / out_stall_i handles_t (one segment per transfer)
// cfg       input      cfg_valid_i / cfg_ready_o cfg_data_i (closed path bit)
//
// After reset a coefficient pass computes MAX_ANCHORS + 1 coefficients through
// the divider; anchors are refused until it ends.
// Anchors are taken one per cycle while the block is idle; the transfer marked
// last starts the solve, which runs on the one shared 32x30 multiplier. No
// anchor is taken until the last segment is in the output register; a stalled
// output holds the sequencer.
module bezier_spline_control_points_top import bscp_pkg::*; #(
  parameter int MAX_ANCHORS = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  anchor_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output handles_t out_data_o,
  input  logic     cfg_valid_i,
  output logic     cfg_ready_o,
  input  logic     cfg_data_i
);

  localparam int AW  = $clog2(MAX_ANCHORS);
  localparam int CW  = $clog2(MAX_ANCHORS + 1);
  localparam int SYS = MAX_ANCHORS + 1;
  localparam int SW  = $clog2(SYS);
  localparam int EXT = MAX_ANCHORS + 3;
  localparam int EW  = $clog2(EXT);

  localparam logic [2:0] PhIssue  = 3'd0;
  localparam logic [2:0] PhLatch  = 3'd1;
  localparam logic [2:0] PhMulLo  = 3'd2;
  localparam logic [2:0] PhMulHi  = 3'd3;
  localparam logic [2:0] PhFinish = 3'd4;
  localparam logic [2:0] PhLatchB = 3'd2;
  localparam logic [2:0] PhDivOp  = 3'd3;
  localparam logic [2:0] PhDivRes = 3'd4;

  typedef enum logic [7:0] {
    ST_INIT = 8'b0000_0001,
    ST_IDLE = 8'b0000_0010,
    ST_FEW  = 8'b0000_0100,
    ST_ENDS = 8'b0000_1000,
    ST_FWD  = 8'b0001_0000,
    ST_BWD  = 8'b0010_0000,
    ST_HND  = 8'b0100_0000,
    ST_EMIT = 8'b1000_0000
  } state_e;

  function automatic logic [AW-1:0] ext_addr(input logic [EW-1:0] j,
                                             input logic [EW-1:0] cnt,
                                             input logic closed);
    logic [AW-1:0] a;
    if (!closed) begin
      a = j[AW-1:0];
    end else if (j == '0) begin
      a = AW'(cnt - EW'(1));
    end else if (j <= cnt) begin
      a = AW'(j - EW'(1));
    end else if (j == cnt + EW'(1)) begin
      a = '0;
    end else begin
      a = AW'(1);
    end
    return a;
  endfunction

  function automatic logic [31:0] sat32(input logic [42:0] v);
    logic [31:0] r;
    if (v[42:31] == '0 || v[42:31] == '1) begin
      r = v[31:0];
    end else begin
      r = v[42] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return r;
  endfunction

  function automatic logic [23:0] sat24(input logic [26:0] v);
    logic [23:0] r;
    if (v[26:23] == '0 || v[26:23] == '1) begin
      r = v[23:0];
    end else begin
      r = v[26] ? 24'h80_0000 : 24'h7F_FFFF;
    end
    return r;
  endfunction

  // Control state.
  state_e         state_q, state_d;
  logic [2:0]     ph_q, ph_d;
  logic [EW-1:0]  i_q, i_d;
  logic           axis_q, axis_d;
  logic [1:0]     hq_q, hq_d;
  logic [5:0]     seg_q, seg_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           ovf_q, ovf_d;
  logic           closed_q;
  logic           mode_q, mode_d;
  logic [CW-1:0]  scnt_q, scnt_d;
  logic [1:0]     stat_q, stat_d;
  logic           out_valid_q, out_valid_d;
  logic [CoefW-1:0] cprev_q, cprev_d;

  // Datapath registers.
  logic [23:0]      p0_q, p0_d, pl_q, pl_d;
  logic [39:0]      dprev_q, dprev_d, dsave_q, dsave_d;
  logic [31:0]      bnext_q, bnext_d;
  logic [40:0]      op_a_q, op_a_d;
  logic [CoefW-1:0] op_c_q, op_c_d;
  logic [61:0]      acc_q, acc_d, prod_q;
  logic [31:0]      ax_q, ax_d, ay_q, ay_d, bx_q, bx_d, by_q, by_d;
  logic [23:0]      hox_q, hox_d, hoy_q, hoy_d, hix_q, hix_d, hiy_q, hiy_d;
  handles_t         out_q, out_d;

  // Memories and their ports.
  logic [47:0]      anc_mem [MAX_ANCHORS];
  logic [CoefW-1:0] coef_mem [SYS];
  logic [39:0]      rhs_mem [SYS];
  logic [31:0]      solx_mem [EXT];
  logic [31:0]      soly_mem [EXT];

  logic [47:0]      anc_rd_q;
  logic [CoefW-1:0] coef_rd_q;
  logic [39:0]      rhs_rd_q;
  logic [31:0]      solx_rd_q, soly_rd_q;

  logic             anc_we;
  logic [AW-1:0]    anc_ra;
  logic             coef_we;
  logic [SW-1:0]    coef_ra;
  logic             rhs_we;
  logic [SW-1:0]    rhs_wa, rhs_ra;
  logic [39:0]      rhs_wd;
  logic             sol_we;
  logic [EW-1:0]    sol_wa, sol_ra;
  logic [31:0]      sol_wd;

  logic [31:0]      mul_a;
  logic [CoefW-1:0] mul_b;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // Derived stroke geometry.
  logic [EW-1:0] m_w, k_w, first_w, last_w;
  logic [CW-1:0] new_cnt;
  logic          accept;

  // Datapath helpers.
  logic [23:0] p_rd;
  logic [27:0] pe, pe0, pel, rhs28;
  logic [40:0] fwd_a, op_mag;
  logic        op_neg;
  logic [71:0] mq_sum;
  logic [40:0] mq_mag;
  logic [41:0] mq_res;
  logic [31:0] mq_sat, bwd_b;
  logic [31:0] sa, sb;
  logic [33:0] sa34, sb34, dv_s, dv_mag, dv_sum;
  logic        dv_neg;
  logic [27:0] dv_v;
  logic [25:0] dq;
  logic [26:0] dr;
  logic [23:0] hres;

  bscp_coef_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign m_w     = EW'(scnt_q) + (mode_q ? EW'(3) : EW'(0));
  assign k_w     = m_w - EW'(2);
  assign first_w = mode_q ? EW'(2) : EW'(1);
  assign last_w  = mode_q ? m_w - EW'(2) : m_w - EW'(1);
  assign new_cnt = (cnt_q < CW'(MAX_ANCHORS)) ? cnt_q + CW'(1) : cnt_q;

  // Forward sweep operand: 64 * (6*P - end terms) - previous d.
  assign p_rd  = axis_q ? anc_rd_q[23:0] : anc_rd_q[47:24];
  assign pe    = {{4{p_rd[23]}}, p_rd};
  assign pe0   = (i_q == '0) ? {{4{p0_q[23]}}, p0_q} : 28'd0;
  assign pel   = (i_q == k_w - EW'(1)) ? {{4{pl_q[23]}}, pl_q} : 28'd0;
  assign rhs28 = (pe << 2) + (pe << 1) - pe0 - pel;
  assign fwd_a = {{7{rhs28[27]}}, rhs28, 6'b0} - {dprev_q[39], dprev_q};

  // Rounded Q2.30 product, built from two partial products.
  assign op_neg = op_a_q[40];
  assign op_mag = op_neg ? 41'd0 - op_a_q : op_a_q;
  assign mq_sum = {10'b0, acc_q} + {prod_q[39:0], 32'b0} + 72'h20000000;
  assign mq_mag = mq_sum[70:30];
  assign mq_res = op_neg ? 42'd0 - {1'b0, mq_mag} : {1'b0, mq_mag};
  assign mq_sat = sat32({mq_res[41], mq_res});
  assign bwd_b  = sat32({{3{dsave_q[39]}}, dsave_q} - {mq_res[41], mq_res});

  // Handle sums divided by 192: shift by six, then multiply by the reciprocal of three.
  assign sa     = hq_q[1] ? ay_q : ax_q;
  assign sb     = hq_q[1] ? by_q : bx_q;
  assign sa34   = {{2{sa[31]}}, sa};
  assign sb34   = {{2{sb[31]}}, sb};
  assign dv_s   = hq_q[0] ? sa34 + (sb34 << 1) : (sa34 << 1) + sb34;
  assign dv_neg = dv_s[33];
  assign dv_mag = dv_neg ? 34'd0 - dv_s : dv_s;
  assign dv_sum = dv_mag + 34'd96;
  assign dv_v   = dv_sum[33:6];
  assign dq     = prod_q[53:28];
  assign dr     = dv_neg ? 27'd0 - {1'b0, dq} : {1'b0, dq};
  assign hres   = sat24(dr);

  always_comb begin
    state_d     = state_q;
    ph_d        = ph_q;
    i_d         = i_q;
    axis_d      = axis_q;
    hq_d        = hq_q;
    seg_d       = seg_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    mode_d      = mode_q;
    scnt_d      = scnt_q;
    stat_d      = stat_q;
    cprev_d     = cprev_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    p0_d        = p0_q;
    pl_d        = pl_q;
    dprev_d     = dprev_q;
    dsave_d     = dsave_q;
    bnext_d     = bnext_q;
    op_a_d      = op_a_q;
    op_c_d      = op_c_q;
    acc_d       = acc_q;
    ax_d        = ax_q;
    ay_d        = ay_q;
    bx_d        = bx_q;
    by_d        = by_q;
    hox_d       = hox_q;
    hoy_d       = hoy_q;
    hix_d       = hix_q;
    hiy_d       = hiy_q;

    anc_we  = 1'b0;
    anc_ra  = '0;
    coef_we = 1'b0;
    coef_ra = '0;
    rhs_we  = 1'b0;
    rhs_wa  = i_q[SW-1:0];
    rhs_ra  = '0;
    rhs_wd  = mq_res[39:0];
    sol_we  = 1'b0;
    sol_wa  = '0;
    sol_ra  = '0;
    sol_wd  = '0;
    mul_a   = '0;
    mul_b   = '0;

    div_req.start = 1'b0;
    div_req.prev  = cprev_q;

    case (state_q)
      ST_INIT: begin
        if (ph_q == PhIssue) begin
          div_req.start = 1'b1;
          ph_d          = PhLatch;
        end else if (div_rsp.done) begin
          coef_we = 1'b1;
          cprev_d = div_rsp.quot;
          ph_d    = PhIssue;
          if (i_q == EW'(MAX_ANCHORS)) begin
            state_d = ST_IDLE;
            i_d     = '0;
          end else begin
            i_d = i_q + EW'(1);
          end
        end
      end

      ST_IDLE: begin
        if (accept) begin
          if (cnt_q < CW'(MAX_ANCHORS)) begin
            anc_we = 1'b1;
            cnt_d  = cnt_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_data_i.last_anchor) begin
            scnt_d = new_cnt;
            stat_d = (ovf_q || cnt_q == CW'(MAX_ANCHORS)) ? StatTrunc : StatOk;
            mode_d = closed_q;
            cnt_d  = '0;
            ovf_d  = 1'b0;
            axis_d = 1'b0;
            ph_d   = PhIssue;
            state_d = (new_cnt < CW'(3)) ? ST_FEW : ST_ENDS;
          end
        end
      end

      ST_FEW: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          out_d.status       = StatFew;
          out_d.last_segment = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      ST_ENDS: begin
        case (ph_q)
          PhIssue: begin
            anc_ra = ext_addr('0, EW'(scnt_q), mode_q);
            ph_d   = PhLatch;
          end
          PhLatch: begin
            p0_d   = p_rd;
            sol_we = 1'b1;
            sol_wa = '0;
            sol_wd = {{2{p_rd[23]}}, p_rd, 6'b0};
            anc_ra = ext_addr(m_w - EW'(1), EW'(scnt_q), mode_q);
            ph_d   = PhMulLo;
          end
          default: begin
            pl_d    = p_rd;
            sol_we  = 1'b1;
            sol_wa  = m_w - EW'(1);
            sol_wd  = {{2{p_rd[23]}}, p_rd, 6'b0};
            dprev_d = '0;
            i_d     = '0;
            ph_d    = PhIssue;
            state_d = ST_FWD;
          end
        endcase
      end

      ST_FWD: begin
        case (ph_q)
          PhIssue: begin
            anc_ra  = ext_addr(i_q + EW'(1), EW'(scnt_q), mode_q);
            coef_ra = i_q[SW-1:0];
            ph_d    = PhLatch;
          end
          PhLatch: begin
            op_a_d = fwd_a;
            op_c_d = coef_rd_q;
            ph_d   = PhMulLo;
          end
          PhMulLo: begin
            mul_a = op_mag[31:0];
            mul_b = op_c_q;
            ph_d  = PhMulHi;
          end
          PhMulHi: begin
            acc_d = prod_q;
            mul_a = {23'b0, op_mag[40:32]};
            mul_b = op_c_q;
            ph_d  = PhFinish;
          end
          default: begin
            rhs_we  = 1'b1;
            dprev_d = mq_res[39:0];
            ph_d    = PhIssue;
            if (i_q == k_w - EW'(1)) begin
              // The last interior point is the start of the back sweep.
              sol_we  = 1'b1;
              sol_wa  = k_w;
              sol_wd  = mq_sat;
              bnext_d = mq_sat;
              if (k_w == EW'(1)) begin
                if (!axis_q) begin
                  axis_d  = 1'b1;
                  state_d = ST_ENDS;
                end else begin
                  i_d     = first_w;
                  seg_d   = '0;
                  state_d = ST_HND;
                end
              end else begin
                i_d     = k_w - EW'(1);
                state_d = ST_BWD;
              end
            end else begin
              i_d = i_q + EW'(1);
            end
          end
        endcase
      end

      ST_BWD: begin
        case (ph_q)
          PhIssue: begin
            rhs_ra  = SW'(i_q - EW'(1));
            coef_ra = SW'(i_q - EW'(1));
            ph_d    = PhLatch;
          end
          PhLatch: begin
            op_a_d  = {{9{bnext_q[31]}}, bnext_q};
            op_c_d  = coef_rd_q;
            dsave_d = rhs_rd_q;
            ph_d    = PhMulLo;
          end
          PhMulLo: begin
            mul_a = op_mag[31:0];
            mul_b = op_c_q;
            ph_d  = PhMulHi;
          end
          PhMulHi: begin
            acc_d = prod_q;
            mul_a = {23'b0, op_mag[40:32]};
            mul_b = op_c_q;
            ph_d  = PhFinish;
          end
          default: begin
            sol_we  = 1'b1;
            sol_wa  = i_q;
            sol_wd  = bwd_b;
            bnext_d = bwd_b;
            ph_d    = PhIssue;
            if (i_q == EW'(1)) begin
              if (!axis_q) begin
                axis_d  = 1'b1;
                state_d = ST_ENDS;
              end else begin
                i_d     = first_w;
                seg_d   = '0;
                state_d = ST_HND;
              end
            end else begin
              i_d = i_q - EW'(1);
            end
          end
        endcase
      end

      ST_HND: begin
        case (ph_q)
          PhIssue: begin
            sol_ra = i_q - EW'(1);
            ph_d   = PhLatch;
          end
          PhLatch: begin
            ax_d   = solx_rd_q;
            ay_d   = soly_rd_q;
            sol_ra = i_q;
            ph_d   = PhLatchB;
          end
          PhLatchB: begin
            bx_d = solx_rd_q;
            by_d = soly_rd_q;
            hq_d = '0;
            ph_d = PhDivOp;
          end
          PhDivOp: begin
            mul_a = {4'b0, dv_v};
            mul_b = Recip3;
            ph_d  = PhDivRes;
          end
          default: begin
            case (hq_q)
              2'd0:    hox_d = hres;
              2'd1:    hix_d = hres;
              2'd2:    hoy_d = hres;
              default: hiy_d = hres;
            endcase
            if (hq_q == 2'd3) begin
              ph_d    = PhIssue;
              state_d = ST_EMIT;
            end else begin
              hq_d = hq_q + 2'd1;
              ph_d = PhDivOp;
            end
          end
        endcase
      end

      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d                = 1'b1;
          out_d.handle_out_x         = hox_q;
          out_d.handle_out_y         = hoy_q;
          out_d.handle_in_x          = hix_q;
          out_d.handle_in_y          = hiy_q;
          out_d.segment_number       = seg_q;
          out_d.status               = stat_q;
          out_d.last_segment         = (i_q == last_w);
          if (i_q == last_w) begin
            state_d = ST_IDLE;
          end else begin
            i_d     = i_q + EW'(1);
            seg_d   = seg_q + 6'd1;
            state_d = ST_HND;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      ph_q        <= PhIssue;
      i_q         <= '0;
      axis_q      <= 1'b0;
      hq_q        <= '0;
      seg_q       <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      closed_q    <= 1'b0;
      mode_q      <= 1'b0;
      scnt_q      <= '0;
      stat_q      <= StatOk;
      out_valid_q <= 1'b0;
      cprev_q     <= '0;
    end else begin
      state_q     <= state_d;
      ph_q        <= ph_d;
      i_q         <= i_d;
      axis_q      <= axis_d;
      hq_q        <= hq_d;
      seg_q       <= seg_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      mode_q      <= mode_d;
      scnt_q      <= scnt_d;
      stat_q      <= stat_d;
      out_valid_q <= out_valid_d;
      cprev_q     <= cprev_d;
      if (cfg_valid_i && cfg_ready_o) begin
        closed_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p0_q    <= p0_d;
    pl_q    <= pl_d;
    dprev_q <= dprev_d;
    dsave_q <= dsave_d;
    bnext_q <= bnext_d;
    op_a_q  <= op_a_d;
    op_c_q  <= op_c_d;
    acc_q   <= acc_d;
    prod_q  <= mul_a * mul_b;
    ax_q    <= ax_d;
    ay_q    <= ay_d;
    bx_q    <= bx_d;
    by_q    <= by_d;
    hox_q   <= hox_d;
    hoy_q   <= hoy_d;
    hix_q   <= hix_d;
    hiy_q   <= hiy_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (anc_we) begin
      anc_mem[cnt_q[AW-1:0]] <= {in_data_i.anchor_x, in_data_i.anchor_y};
    end
    anc_rd_q <= anc_mem[anc_ra];
  end

  always_ff @(posedge clk_i) begin
    if (coef_we) begin
      coef_mem[i_q[SW-1:0]] <= div_rsp.quot;
    end
    coef_rd_q <= coef_mem[coef_ra];
  end

  always_ff @(posedge clk_i) begin
    if (rhs_we) begin
      rhs_mem[rhs_wa] <= rhs_wd;
    end
    rhs_rd_q <= rhs_mem[rhs_ra];
  end

  always_ff @(posedge clk_i) begin
    if (sol_we && !axis_q) begin
      solx_mem[sol_wa] <= sol_wd;
    end
    solx_rd_q <= solx_mem[sol_ra];
  end

  always_ff @(posedge clk_i) begin
    if (sol_we && axis_q) begin
      soly_mem[sol_wa] <= sol_wd;
    end
    soly_rd_q <= soly_mem[sol_ra];
  end

endmodule

// File: tb/tb_bezier_spline_control_points_top.sv
`timescale 1ns / 1ps

module tb_bezier_spline_control_points_top import bscp_pkg::*; ();

  localparam int MaxAnchors = 64;
  localparam int ErrShown   = 10;
  localparam longint KnotMin = -64'sd2147483648;
  localparam longint KnotMax = 64'sd2147483647;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  anchor_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  handles_t out_data_o;
  logic     cfg_valid_i;
  logic     cfg_ready_o;
  logic     cfg_data_i;

  bezier_spline_control_points_top #(.MAX_ANCHORS(MaxAnchors)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // Spline predictor state.
  int               pts_x [MaxAnchors];
  int               pts_y [MaxAnchors];
  int unsigned      stroke_len;
  bit               stroke_dropped;
  bit               closed_mode;
  int               ext_pts [MaxAnchors + 3];
  longint unsigned  sweep_coef [MaxAnchors + 1];
  longint           sweep_rhs [MaxAnchors + 1];
  longint           knots [MaxAnchors + 3];

  handles_t pending_handles[$];
  int       anchors_sent;
  int       segments_seen;
  int       strokes_sent;
  int       mismatches;
  bit       quiet;
  int       hold_len;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #30ms;
    $display("simulation failed");
    $finish;
  end

  function automatic longint mul_q30(longint a, longint unsigned c);
    bit              neg;
    longint unsigned mag;
    longint unsigned r;
    neg = a < 0;
    mag = neg ? longint'(-a) : a;
    r   = (mag * c + (64'd1 << 29)) >> 30;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint div_by_192(longint a);
    bit              neg;
    longint unsigned mag;
    longint unsigned r;
    neg = a < 0;
    mag = neg ? longint'(-a) : a;
    r   = (mag + 96) / 192;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic signed [CoordW-1:0] handle_coord(longint a, longint b);
    return CoordW'(clamp(div_by_192(2 * a + b), -8388608, 8388607));
  endfunction

  // Thomas algorithm over ext_pts[0..m-1]; end knots are the end anchors.
  function automatic void solve_knots(int m);
    int              k;
    longint unsigned prev_c;
    longint          prev_d;
    longint          rhs;
    longint unsigned den;
    longint unsigned c;
    k      = m - 2;
    prev_c = 0;
    prev_d = 0;
    for (int i = 0; i < k; i++) begin
      rhs = 6 * longint'(ext_pts[i + 1]);
      if (i == 0) rhs -= ext_pts[0];
      if (i == k - 1) rhs -= ext_pts[m - 1];
      den = 4 * (64'd1 << 30) - prev_c;
      c = ((64'd1 << 60) + den / 2) / den;
      sweep_coef[i] = c;
      prev_d = mul_q30(rhs * 64 - prev_d, c);
      sweep_rhs[i] = prev_d;
      prev_c = c;
    end
    knots[0]     = longint'(ext_pts[0]) * 64;
    knots[m - 1] = longint'(ext_pts[m - 1]) * 64;
    knots[k]     = clamp(sweep_rhs[k - 1], KnotMin, KnotMax);
    for (int i = k - 1; i >= 1; i--)
      knots[i] = clamp(sweep_rhs[i - 1] - mul_q30(knots[i + 1], sweep_coef[i - 1]),
                       KnotMin, KnotMax);
  endfunction

  function automatic void predict_anchor(anchor_t a);
    int unsigned cnt, m, first, last;
    logic [1:0]  stat;
    handles_t    segs [MaxAnchors + 1];
    if (stroke_len < MaxAnchors) begin
      pts_x[stroke_len] = a.anchor_x;
      pts_y[stroke_len] = a.anchor_y;
      stroke_len++;
    end else begin
      stroke_dropped = 1'b1;
    end
    if (!a.last_anchor) return;
    cnt  = stroke_len;
    stat = stroke_dropped ? StatTrunc : StatOk;
    stroke_len     = 0;
    stroke_dropped = 1'b0;
    if (cnt < 3) begin
      segs[0] = '0;
      segs[0].status       = StatFew;
      segs[0].last_segment = 1'b1;
      pending_handles.push_back(segs[0]);
      return;
    end
    m     = closed_mode ? cnt + 3 : cnt;
    first = closed_mode ? 2 : 1;
    last  = closed_mode ? m - 2 : m - 1;
    for (int axis = 0; axis < 2; axis++) begin
      for (int i = 0; i < cnt; i++)
        ext_pts[i + (closed_mode ? 1 : 0)] = axis ? pts_y[i] : pts_x[i];
      if (closed_mode) begin
        ext_pts[0]       = ext_pts[cnt];
        ext_pts[cnt + 1] = ext_pts[1];
        ext_pts[cnt + 2] = ext_pts[2];
      end
      solve_knots(m);
      for (int n = first; n <= last; n++) begin
        if (axis == 0) begin
          segs[n - first].handle_out_x = handle_coord(knots[n - 1], knots[n]);
          segs[n - first].handle_in_x  = handle_coord(knots[n], knots[n - 1]);
        end else begin
          segs[n - first].handle_out_y = handle_coord(knots[n - 1], knots[n]);
          segs[n - first].handle_in_y  = handle_coord(knots[n], knots[n - 1]);
        end
      end
    end
    for (int i = 0; i <= last - first; i++) begin
      segs[i].segment_number = 6'(i);
      segs[i].status         = stat;
      segs[i].last_segment   = (i == last - first);
      pending_handles.push_back(segs[i]);
    end
  endfunction

  // Output checker: every transfer is compared with the oldest expectation.
  always @(posedge clk_i) begin
    handles_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      segments_seen++;
      if (pending_handles.size() == 0) begin
        mismatches++;
        if (mismatches <= ErrShown) $display("unexpected segment %p", out_data_o);
      end else begin
        want = pending_handles.pop_front();
        if (want !== out_data_o) begin
          mismatches++;
          if (mismatches <= ErrShown)
            $display("segment mismatch: expected %p, got %p", want, out_data_o);
        end
      end
    end
  end

  // Receiver: random stall before each transfer, plus an optional long hold.
  initial begin
    int n;
    out_stall_i = 1'b1;
    forever begin
      @(negedge clk_i);
      if (hold_len > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_len) @(negedge clk_i);
        hold_len = 0;
      end
      n = quiet ? 0 : $urandom_range(0, 7);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_anchor(input logic signed [CoordW-1:0] x,
                             input logic signed [CoordW-1:0] y, input logic last);
    int      gap;
    anchor_t a;
    gap = quiet ? 0 : $urandom_range(0, 7);
    a.anchor_x = x;
    a.anchor_y = y;
    a.last_anchor = last;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= a;
    do @(posedge clk_i); while (in_stall_o);
    predict_anchor(a);
    anchors_sent++;
    if (last) strokes_sent++;
  endtask

  function automatic logic signed [CoordW-1:0] rand_coord();
    case ($urandom_range(0, 4))
      0:       return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
      1:       return CoordW'($urandom_range(0, 4096)) - 24'sd2048;
      default: return CoordW'($urandom());
    endcase
  endfunction

  task automatic send_stroke(int len);
    for (int i = 0; i < len; i++) send_anchor(rand_coord(), rand_coord(), i == len - 1);
  endtask

  // Waits for the block to drain, then writes the closed path bit.
  task automatic set_closed(bit v);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending_handles.size() == 0);
    repeat (40) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    closed_mode = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_short_strokes();
    send_anchor(24'sh7fffff, 24'sh800000, 1'b1);
    send_anchor(24'sh000100, 24'sh000200, 1'b0);
    send_anchor(24'sh800000, 24'sh7fffff, 1'b1);
  endtask

  task automatic test_open_extremes();
    send_anchor(24'sh800000, 24'sh7fffff, 1'b0);
    send_anchor(24'sh7fffff, 24'sh800000, 1'b0);
    send_anchor(24'sh800000, 24'sh7fffff, 1'b1);
    send_anchor(24'sh000000, 24'sh000000, 1'b0);
    send_anchor(24'sh000300, 24'shfffd00, 1'b0);
    send_anchor(24'sh001000, 24'sh000500, 1'b0);
    send_anchor(-24'sh000001, 24'sh000001, 1'b1);
  endtask

  task automatic test_closed_loops();
    set_closed(1'b1);
    send_anchor(24'sh7fffff, 24'sh7fffff, 1'b0);
    send_anchor(24'sh800000, 24'sh000000, 1'b0);
    send_anchor(24'sh000000, 24'sh800000, 1'b1);
    send_anchor(24'sh000100, 24'sh000100, 1'b1);
    send_stroke(6);
  endtask

  task automatic test_truncation();
    send_stroke(MaxAnchors + 2);
    set_closed(1'b0);
    send_stroke(MaxAnchors + 1);
    send_stroke(MaxAnchors);
  endtask

  // The receiver holds off while three strokes are sent; the stalled output blocks further anchors.
  task automatic test_backpressure();
    hold_len = 600;
    quiet = 1'b1;
    send_stroke(5);
    send_stroke(4);
    send_stroke(3);
    quiet = 1'b0;
  endtask

  task automatic test_random_strokes();
    int len;
    int target;
    target = anchors_sent + 80;
    while (anchors_sent < target) begin
      if ($urandom_range(0, 9) == 0) set_closed($urandom_range(0, 1));
      quiet = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 9))
        0:       len = $urandom_range(1, 2);
        1:       len = $urandom_range(13, 24);
        default: len = $urandom_range(3, 12);
      endcase
      send_stroke(len);
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = 1'b0;
    closed_mode = 1'b0;
    stroke_len  = 0;
    stroke_dropped = 1'b0;
    quiet       = 1'b0;
    hold_len    = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    set_closed(1'b0);
    test_short_strokes();
    test_open_extremes();
    test_closed_loops();
    test_truncation();
    test_backpressure();
    test_random_strokes();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending_handles.size() == 0);
    repeat (200) @(negedge clk_i);

    $display("Sent %0d anchors in %0d strokes, checked %0d segments.",
             anchors_sent, strokes_sent, segments_seen);
    $display("Open and closed paths, short and truncated strokes, %0d mismatches.",
             mismatches);
    if (mismatches == 0 && pending_handles.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
